### rtl/core/tiny_register_cpu_step_macros.svh
// Assertion macros for the tiny register machine step block.
// No dependencies; included by modules that carry concurrent checks.
`ifndef TINY_REGISTER_CPU_STEP_MACROS_SVH
`define TINY_REGISTER_CPU_STEP_MACROS_SVH
`ifndef SYNTHESIS
// Implication or plain property, sampled on clk, off while in reset.
`define TRCS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true.
`define TRCS_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define TRCS_ASSERT(lbl, prop, msg)
`define TRCS_NEVER(lbl, cond, msg)
`endif
`endif

### rtl/core/trcs_pkg.sv
// Shared types and codes of the tiny register machine step block.
// No dependencies; used by trcs_mem, tiny_register_cpu_step and the testbench.
package trcs_pkg;

    // Command codes
    localparam logic [1:0] CMD_EXEC  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_RREG  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_REG = 2'd1;
    localparam logic [1:0] ST_BAD_OP  = 2'd2;

    // Opcodes
    localparam logic [7:0] OP_MOVI  = 8'h10;
    localparam logic [7:0] OP_MOVR  = 8'h11;
    localparam logic [7:0] OP_STORE = 8'h12;
    localparam logic [7:0] OP_LOAD  = 8'h13;
    localparam logic [7:0] OP_ADD   = 8'h14;
    localparam logic [7:0] OP_JNE   = 8'h15;

    // Width of a memory address as carried between modules
    localparam int ADDR_W = 16;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DEC,
        S_ARG,
        S_EXEC,
        S_MRD,
        S_RRD,
        S_MOV,
        S_ST0,
        S_ST1,
        S_LD0,
        S_LD1,
        S_ADD0,
        S_ADD1,
        S_JMP
    } state_t;

    // One byte access to the main memory
    typedef struct packed {
        logic              rd;
        logic              wr;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wdata;
    } mem_req_t;

endpackage

### rtl/core/trcs_mem.sv
// Byte-wide main memory with one port, registered read and a zeroing sweep.
// Depends on trcs_pkg for the request struct.
module trcs_mem #(
    parameter int ADDR_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  trcs_pkg::mem_req_t req,
    output logic [7:0]        rdata,
    output logic              ready
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [7:0]           mem [DEPTH];
    logic [ADDR_BITS-1:0] clr_addr_reg;
    logic [ADDR_BITS-1:0] clr_addr_next;
    logic                 clearing_reg;
    logic                 clearing_next;
    logic [7:0]           rdata_reg;
    logic [ADDR_BITS-1:0] req_addr;

    assign req_addr = req.addr[ADDR_BITS-1:0];

    // Advance the zeroing sweep, drop it after the last byte
    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        clearing_next = clearing_reg;
        if (clearing_reg)
        begin
            clr_addr_next = clr_addr_reg + 1'b1;
            if (clr_addr_reg == {ADDR_BITS{1'b1}})
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clearing_reg <= 1'b1;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            clearing_reg <= clearing_next;
        end
    end

    // Write a zero during the sweep, else the requested byte; register reads
    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= 8'h00;
        end
        else if (req.wr)
        begin
            mem[req_addr] <= req.wdata;
        end
        if (req.rd)
        begin
            rdata_reg <= mem[req_addr];
        end
    end

    assign rdata = rdata_reg;
    assign ready = !clearing_reg;

endmodule

### rtl/core/tiny_register_cpu_step.sv
// Top level of the tiny register machine step block: command sequencer and
// register file. Depends on trcs_pkg, trcs_mem and the assertion macro header.

// One command is taken at a time (start while busy is low) and gives exactly
// one result word, shown with done high for a single cycle; the receiver
// cannot stall it, so capture the outputs when done is high. A memory write,
// or a register read with an index out of range, answers in the cycle after
// start; a memory or register read answers from the S_MRD or S_RRD state. An
// execute command fetches the opcode and then each operand byte from the
// single-port byte memory, then does its register file and data memory
// accesses; an unknown opcode ends at decode. After reset the memory is
// zeroed one byte per cycle, and busy stays high until the sweep has passed
// the last byte, before the first command can be taken.
`include "tiny_register_cpu_step_macros.svh"

module tiny_register_cpu_step #(
    parameter int MEM_ADDR_BITS = 16,
    parameter int NUM_REGS      = 9
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [15:0] address,
    input  logic [7:0]  write_byte,
    output logic        done,
    output logic [15:0] read_data,
    output logic [7:0]  pc_value,
    output logic [1:0]  status,
    output logic        branch_taken
);

    localparam int IDX_BITS = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    trcs_pkg::state_t   state_reg;
    trcs_pkg::state_t   state_next;
    logic [7:0]         pc_reg;
    logic [7:0]         pc_next;
    logic [7:0]         op_reg;
    logic [7:0]         op_next;
    logic [2:0][7:0]    arg_reg;
    logic [2:0][7:0]    arg_next;
    logic [1:0]         arg_cnt_reg;
    logic [1:0]         arg_cnt_next;
    logic [1:0]         arg_last;
    logic [15:0]        tmp_reg;
    logic [15:0]        tmp_next;
    logic               done_reg;
    logic               done_next;
    logic [15:0]        read_data_reg;
    logic [15:0]        read_data_next;
    logic [1:0]         status_reg;
    logic [1:0]         status_next;
    logic               taken_reg;
    logic               taken_next;

    trcs_pkg::mem_req_t mem_req;
    logic [7:0]         mem_rdata;
    logic               mem_ready;

    logic [15:0]        rf_mem [NUM_REGS];
    logic [NUM_REGS-1:0] rf_valid_reg;
    logic [15:0]        rf_rdata_reg;
    logic               rf_rd;
    logic [IDX_BITS-1:0] rf_ridx;
    logic               rf_we;
    logic [IDX_BITS-1:0] rf_widx;
    logic [15:0]        rf_wdata;

    logic               accept;
    logic               ok0;
    logic               ok1;
    logic               ok2;
    logic [15:0]        imm_lo;
    logic [15:0]        imm_hi;

    assign busy   = (state_reg != trcs_pkg::S_IDLE) || !mem_ready;
    assign accept = start && !busy;

    // Index checks on the operand bytes
    assign ok0    = arg_reg[0] < 8'(NUM_REGS);
    assign ok1    = arg_reg[1] < 8'(NUM_REGS);
    assign ok2    = arg_reg[2] < 8'(NUM_REGS);
    assign imm_lo = {arg_reg[1], arg_reg[0]};
    assign imm_hi = {arg_reg[2], arg_reg[1]};

    // Index of the last operand byte for each known opcode
    always_comb
    begin
        unique case (op_reg)
            trcs_pkg::OP_MOVR, trcs_pkg::OP_ADD: arg_last = 2'd1;
            trcs_pkg::OP_JNE:                    arg_last = 2'd3;
            default:                             arg_last = 2'd2;
        endcase
    end

    trcs_mem #(
        .ADDR_BITS (MEM_ADDR_BITS)
    ) u_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mem_req),
        .rdata (mem_rdata),
        .ready (mem_ready)
    );

    // Sequence one command: fetch bytes, access registers and memory, finish
    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        op_next        = op_reg;
        arg_next       = arg_reg;
        arg_cnt_next   = arg_cnt_reg;
        tmp_next       = tmp_reg;
        done_next      = 1'b0;
        read_data_next = read_data_reg;
        status_next    = status_reg;
        taken_next     = taken_reg;
        mem_req        = '0;
        rf_rd          = 1'b0;
        rf_ridx        = '0;
        rf_we          = 1'b0;
        rf_widx        = '0;
        rf_wdata       = '0;

        unique case (state_reg)
            trcs_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    read_data_next = '0;
                    status_next    = trcs_pkg::ST_OK;
                    taken_next     = 1'b0;
                    unique case (cmd)
                        trcs_pkg::CMD_EXEC:
                        begin
                            mem_req.rd   = 1'b1;
                            mem_req.addr = {8'h00, pc_reg};
                            pc_next      = pc_reg + 8'd1;
                            state_next   = trcs_pkg::S_DEC;
                        end
                        trcs_pkg::CMD_WRITE:
                        begin
                            mem_req.wr    = 1'b1;
                            mem_req.addr  = address;
                            mem_req.wdata = write_byte;
                            done_next     = 1'b1;
                        end
                        trcs_pkg::CMD_READ:
                        begin
                            mem_req.rd   = 1'b1;
                            mem_req.addr = address;
                            state_next   = trcs_pkg::S_MRD;
                        end
                        default:
                        begin
                            if (address < 16'(NUM_REGS))
                            begin
                                rf_rd      = 1'b1;
                                rf_ridx    = address[IDX_BITS-1:0];
                                state_next = trcs_pkg::S_RRD;
                            end
                            else
                            begin
                                status_next = trcs_pkg::ST_BAD_REG;
                                done_next   = 1'b1;
                            end
                        end
                    endcase
                end
            end
            trcs_pkg::S_MRD:
            begin
                read_data_next = {8'h00, mem_rdata};
                done_next      = 1'b1;
                state_next     = trcs_pkg::S_IDLE;
            end
            trcs_pkg::S_RRD:
            begin
                read_data_next = rf_rdata_reg;
                done_next      = 1'b1;
                state_next     = trcs_pkg::S_IDLE;
            end
            trcs_pkg::S_DEC:
            begin
                op_next = mem_rdata;
                case (mem_rdata) inside
                    [trcs_pkg::OP_MOVI:trcs_pkg::OP_JNE]:
                    begin
                        mem_req.rd   = 1'b1;
                        mem_req.addr = {8'h00, pc_reg};
                        pc_next      = pc_reg + 8'd1;
                        arg_cnt_next = 2'd0;
                        state_next   = trcs_pkg::S_ARG;
                    end
                    default:
                    begin
                        status_next = trcs_pkg::ST_BAD_OP;
                        done_next   = 1'b1;
                        state_next  = trcs_pkg::S_IDLE;
                    end
                endcase
            end
            trcs_pkg::S_ARG:
            begin
                // Keep the byte; the jump target high byte is not needed
                if (arg_cnt_reg != 2'd3)
                begin
                    arg_next[arg_cnt_reg] = mem_rdata;
                end
                if (arg_cnt_reg == arg_last)
                begin
                    state_next = trcs_pkg::S_EXEC;
                end
                else
                begin
                    mem_req.rd   = 1'b1;
                    mem_req.addr = {8'h00, pc_reg};
                    pc_next      = pc_reg + 8'd1;
                    arg_cnt_next = arg_cnt_reg + 2'd1;
                end
            end
            trcs_pkg::S_EXEC:
            begin
                state_next = trcs_pkg::S_IDLE;
                unique case (op_reg)
                    trcs_pkg::OP_MOVI:
                    begin
                        done_next = 1'b1;
                        if (ok2)
                        begin
                            rf_we    = 1'b1;
                            rf_widx  = arg_reg[2][IDX_BITS-1:0];
                            rf_wdata = imm_lo;
                        end
                        else
                        begin
                            status_next = trcs_pkg::ST_BAD_REG;
                        end
                    end
                    trcs_pkg::OP_MOVR, trcs_pkg::OP_ADD:
                    begin
                        if (ok0 && ok1)
                        begin
                            rf_rd      = 1'b1;
                            rf_ridx    = arg_reg[0][IDX_BITS-1:0];
                            state_next = (op_reg == trcs_pkg::OP_MOVR) ?
                                         trcs_pkg::S_MOV : trcs_pkg::S_ADD0;
                        end
                        else
                        begin
                            status_next = trcs_pkg::ST_BAD_REG;
                            done_next   = 1'b1;
                        end
                    end
                    trcs_pkg::OP_STORE:
                    begin
                        if (ok0)
                        begin
                            rf_rd      = 1'b1;
                            rf_ridx    = arg_reg[0][IDX_BITS-1:0];
                            state_next = trcs_pkg::S_ST0;
                        end
                        else
                        begin
                            status_next = trcs_pkg::ST_BAD_REG;
                            done_next   = 1'b1;
                        end
                    end
                    trcs_pkg::OP_LOAD:
                    begin
                        if (ok2)
                        begin
                            mem_req.rd   = 1'b1;
                            mem_req.addr = imm_lo;
                            state_next   = trcs_pkg::S_LD0;
                        end
                        else
                        begin
                            status_next = trcs_pkg::ST_BAD_REG;
                            done_next   = 1'b1;
                        end
                    end
                    default:
                    begin
                        // Conditional jump: fetch the accumulator
                        rf_rd      = 1'b1;
                        rf_ridx    = '0;
                        state_next = trcs_pkg::S_JMP;
                    end
                endcase
            end
            trcs_pkg::S_MOV:
            begin
                rf_we      = 1'b1;
                rf_widx    = arg_reg[1][IDX_BITS-1:0];
                rf_wdata   = rf_rdata_reg;
                done_next  = 1'b1;
                state_next = trcs_pkg::S_IDLE;
            end
            trcs_pkg::S_ST0:
            begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = imm_hi;
                mem_req.wdata = rf_rdata_reg[7:0];
                tmp_next      = rf_rdata_reg;
                state_next    = trcs_pkg::S_ST1;
            end
            trcs_pkg::S_ST1:
            begin
                mem_req.wr    = 1'b1;
                mem_req.addr  = imm_hi + 16'd1;
                mem_req.wdata = tmp_reg[15:8];
                done_next     = 1'b1;
                state_next    = trcs_pkg::S_IDLE;
            end
            trcs_pkg::S_LD0:
            begin
                mem_req.rd   = 1'b1;
                mem_req.addr = imm_lo + 16'd1;
                tmp_next     = {8'h00, mem_rdata};
                state_next   = trcs_pkg::S_LD1;
            end
            trcs_pkg::S_LD1:
            begin
                rf_we      = 1'b1;
                rf_widx    = arg_reg[2][IDX_BITS-1:0];
                rf_wdata   = {mem_rdata, tmp_reg[7:0]};
                done_next  = 1'b1;
                state_next = trcs_pkg::S_IDLE;
            end
            trcs_pkg::S_ADD0:
            begin
                tmp_next   = rf_rdata_reg;
                rf_rd      = 1'b1;
                rf_ridx    = arg_reg[1][IDX_BITS-1:0];
                state_next = trcs_pkg::S_ADD1;
            end
            trcs_pkg::S_ADD1:
            begin
                rf_we      = 1'b1;
                rf_widx    = '0;
                rf_wdata   = tmp_reg + rf_rdata_reg;
                done_next  = 1'b1;
                state_next = trcs_pkg::S_IDLE;
            end
            trcs_pkg::S_JMP:
            begin
                if (rf_rdata_reg != imm_lo)
                begin
                    pc_next    = arg_reg[2];
                    taken_next = 1'b1;
                end
                done_next  = 1'b1;
                state_next = trcs_pkg::S_IDLE;
            end
            default:
            begin
                state_next = trcs_pkg::S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= trcs_pkg::S_IDLE;
            pc_reg       <= 8'h00;
            done_reg     <= 1'b0;
            rf_valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            done_reg  <= done_next;
            if (rf_we)
            begin
                rf_valid_reg[rf_widx] <= 1'b1;
            end
        end
    end

    // Hold operands and the result word
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        arg_reg       <= arg_next;
        arg_cnt_reg   <= arg_cnt_next;
        tmp_reg       <= tmp_next;
        read_data_reg <= read_data_next;
        status_reg    <= status_next;
        taken_reg     <= taken_next;
    end

    // Register file: one write, one registered read; unwritten entries read zero
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[rf_widx] <= rf_wdata;
        end
        if (rf_rd)
        begin
            rf_rdata_reg <= rf_valid_reg[rf_ridx] ? rf_mem[rf_ridx] : 16'h0000;
        end
    end

    assign done         = done_reg;
    assign read_data    = read_data_reg;
    assign pc_value     = pc_reg;
    assign status       = status_reg;
    assign branch_taken = taken_reg;

    // Checks
    `TRCS_ASSERT(a_accept_progress, accept |=> (busy || done), "accepted word lost")
    `TRCS_NEVER(a_no_write_in_clear, mem_req.wr && !mem_ready, "memory write during sweep")
    `TRCS_NEVER(a_rf_index, rf_we && (32'(rf_widx) >= NUM_REGS), "register index out of range")
    `TRCS_ASSERT(a_err_clean,
        (done && (status != trcs_pkg::ST_OK)) |-> ((read_data == 16'h0000) && !branch_taken),
        "error result not clean")

endmodule

### tb/sv/tiny_register_cpu_step_tb.sv
// Self-checking testbench for tiny_register_cpu_step: predicts each result word
// from a behavioral model of the register machine. Depends on trcs_pkg and the DUT.
`timescale 1ns / 1ps

module tiny_register_cpu_step_tb;

    localparam int NUM_REGS    = 9;
    localparam int TOTAL_ITEMS = 750;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] addr;
        logic [7:0]  data;
    } command_t;

    typedef struct packed {
        logic [15:0] data;
        logic [7:0]  pc;
        logic [1:0]  status;
        logic        taken;
    } step_result_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  cmd = trcs_pkg::CMD_EXEC;
    logic [15:0] address = 16'h0000;
    logic [7:0]  write_byte = 8'h00;
    logic        busy;
    logic        done;
    logic [15:0] read_data;
    logic [7:0]  pc_value;
    logic [1:0]  status;
    logic        branch_taken;

    // Machine state as predicted from accepted words
    logic [7:0]  cpu_mem [0:65535];
    logic [15:0] cpu_regs [0:NUM_REGS-1];
    logic [7:0]  cpu_pc;

    command_t     command_queue[$];
    step_result_t pending_results[$];
    int           in_flight = 0;
    int           queued_total = 0;
    int           errors = 0;
    int           cycle_count = 0;
    int           burst_left = 1;
    int           gap_left = 0;
    bit           took = 1'b0;

    tiny_register_cpu_step #(
        .MEM_ADDR_BITS (16),
        .NUM_REGS      (NUM_REGS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .address      (address),
        .write_byte   (write_byte),
        .done         (done),
        .read_data    (read_data),
        .pc_value     (pc_value),
        .status       (status),
        .branch_taken (branch_taken)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Fetch one instruction byte and advance the wrapping program counter
    function automatic logic [7:0] fetch_byte();
        logic [7:0] b;
        b = cpu_mem[{8'h00, cpu_pc}];
        cpu_pc = cpu_pc + 8'd1;
        return b;
    endfunction

    function automatic logic [15:0] fetch_word();
        logic [7:0] lo;
        lo = fetch_byte();
        return {fetch_byte(), lo};
    endfunction

    // Apply one command to the machine state and return its result word
    function automatic step_result_t run_command(logic [1:0] c, logic [15:0] a,
                                                 logic [7:0] wb);
        step_result_t r;
        logic [7:0]   opcode;
        logic [7:0]   ra;
        logic [7:0]   rb;
        logic [15:0]  w;
        logic [15:0]  t;
        r = '0;
        case (c)
            trcs_pkg::CMD_EXEC:
            begin
                opcode = fetch_byte();
                case (opcode)
                    trcs_pkg::OP_MOVI:
                    begin
                        w = fetch_word();
                        ra = fetch_byte();
                        if (ra < NUM_REGS) cpu_regs[ra] = w;
                        else r.status = trcs_pkg::ST_BAD_REG;
                    end
                    trcs_pkg::OP_MOVR:
                    begin
                        ra = fetch_byte();
                        rb = fetch_byte();
                        if (ra < NUM_REGS && rb < NUM_REGS) cpu_regs[rb] = cpu_regs[ra];
                        else r.status = trcs_pkg::ST_BAD_REG;
                    end
                    trcs_pkg::OP_STORE:
                    begin
                        ra = fetch_byte();
                        w = fetch_word();
                        if (ra < NUM_REGS)
                        begin
                            cpu_mem[w] = cpu_regs[ra][7:0];
                            cpu_mem[16'(w + 16'd1)] = cpu_regs[ra][15:8];
                        end
                        else r.status = trcs_pkg::ST_BAD_REG;
                    end
                    trcs_pkg::OP_LOAD:
                    begin
                        w = fetch_word();
                        ra = fetch_byte();
                        if (ra < NUM_REGS) cpu_regs[ra] = {cpu_mem[16'(w + 16'd1)], cpu_mem[w]};
                        else r.status = trcs_pkg::ST_BAD_REG;
                    end
                    trcs_pkg::OP_ADD:
                    begin
                        ra = fetch_byte();
                        rb = fetch_byte();
                        if (ra < NUM_REGS && rb < NUM_REGS)
                            cpu_regs[0] = cpu_regs[ra] + cpu_regs[rb];
                        else r.status = trcs_pkg::ST_BAD_REG;
                    end
                    trcs_pkg::OP_JNE:
                    begin
                        w = fetch_word();
                        t = fetch_word();
                        if (w != cpu_regs[0])
                        begin
                            cpu_pc = t[7:0];
                            r.taken = 1'b1;
                        end
                    end
                    default: r.status = trcs_pkg::ST_BAD_OP;
                endcase
            end
            trcs_pkg::CMD_WRITE: cpu_mem[a] = wb;
            trcs_pkg::CMD_READ:  r.data = {8'h00, cpu_mem[a]};
            default:
            begin
                if (a < NUM_REGS) r.data = cpu_regs[a];
                else r.status = trcs_pkg::ST_BAD_REG;
            end
        endcase
        r.pc = cpu_pc;
        return r;
    endfunction

    task automatic push_item(input logic [1:0] c, input logic [15:0] a, input logic [7:0] wb);
        command_t item;
        item.op = c;
        item.addr = a;
        item.data = wb;
        command_queue.push_back(item);
        in_flight++;
        queued_total++;
    endtask

    // Hold until every queued word is taken, and optionally until all results are back
    task automatic wait_idle(input bit need_all);
        while (in_flight != 0 || (need_all && pending_results.size() != 0))
            @(negedge clk);
    endtask

    // Place an instruction at the current pc (only bytes that differ) and execute it
    task automatic load_and_run(input logic [39:0] code, input int len);
        logic [7:0] loc;
        for (int k = 0; k < len; k++)
        begin
            loc = cpu_pc + 8'(k);
            if (cpu_mem[{8'h00, loc}] != code[8*k +: 8])
                push_item(trcs_pkg::CMD_WRITE, {8'h00, loc}, code[8*k +: 8]);
        end
        push_item(trcs_pkg::CMD_EXEC, 16'($urandom), 8'($urandom));
    endtask

    function automatic logic [7:0] pick_reg_index();
        case ($urandom_range(0, 15))
            0:       return 8'(NUM_REGS + $urandom_range(0, 255 - NUM_REGS));
            1:       return $urandom_range(0, 1) ? 8'hFF : 8'(NUM_REGS);
            default: return 8'($urandom_range(0, NUM_REGS - 1));
        endcase
    endfunction

    function automatic logic [15:0] pick_data_addr();
        case ($urandom_range(0, 7))
            0:       return 16'hFFFF;
            1:       return 16'hFFFE;
            2:       return {8'h00, 8'($urandom)};
            3, 4:    return 16'($urandom);
            default: return 16'h4000 + 16'($urandom_range(0, 15));
        endcase
    endfunction

    function automatic logic [15:0] pick_imm();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Build one random instruction from the current state; caller has drained
    task automatic queue_random_instr();
        logic [7:0]  opcode;
        logic [7:0]  ra;
        logic [7:0]  rb;
        logic [15:0] w;
        logic [15:0] t;
        ra = pick_reg_index();
        rb = pick_reg_index();
        case ($urandom_range(0, 6))
            0: load_and_run({8'h00, ra, pick_imm(), trcs_pkg::OP_MOVI}, 4);
            1: load_and_run({16'h0000, rb, ra, trcs_pkg::OP_MOVR}, 3);
            2: load_and_run({8'h00, pick_data_addr(), ra, trcs_pkg::OP_STORE}, 4);
            3: load_and_run({8'h00, ra, pick_data_addr(), trcs_pkg::OP_LOAD}, 4);
            4: load_and_run({16'h0000, rb, ra, trcs_pkg::OP_ADD}, 3);
            5:
            begin
                // half the jumps compare equal and fall through
                w = $urandom_range(0, 1) ? cpu_regs[0] : pick_imm();
                t = 16'($urandom);
                load_and_run({t, w, trcs_pkg::OP_JNE}, 5);
            end
            default:
            begin
                opcode = 8'($urandom);
                if (opcode >= trcs_pkg::OP_MOVI && opcode <= trcs_pkg::OP_JNE)
                    opcode = opcode ^ 8'h80;
                load_and_run({32'h0, opcode}, 1);
            end
        endcase
    endtask

    // Drive the next word at the falling edge; hold it until taken
    always @(negedge clk)
    begin : driver
        command_t next_item;
        if (!rst_n) start <= 1'b0;
        else if (!start || took)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                start <= 1'b0;
            end
            else if (command_queue.size() > 0)
            begin
                next_item = command_queue.pop_front();
                cmd <= next_item.op;
                address <= next_item.addr;
                write_byte <= next_item.data;
                start <= 1'b1;
                if (burst_left > 1) burst_left--;
                else
                begin
                    case ($urandom_range(0, 9))
                        0, 1, 2:
                        begin
                            burst_left = $urandom_range(10, 40);
                            gap_left = 0;
                        end
                        3:
                        begin
                            burst_left = $urandom_range(1, 4);
                            gap_left = $urandom_range(15, 40);
                        end
                        default:
                        begin
                            burst_left = $urandom_range(1, 6);
                            gap_left = $urandom_range(1, 8);
                        end
                    endcase
                end
            end
            else start <= 1'b0;
        end
    end

    // Take accepted words into the predictor and check each result word
    always @(posedge clk)
    begin : monitor
        step_result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("TB_ERROR");
            $finish;
        end
        else
        begin
            took = rst_n && start && !busy;
            if (took)
            begin
                pending_results.push_back(run_command(cmd, address, write_byte));
                in_flight--;
            end
            if (rst_n && done)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result word, expected none, got data %0h pc %0h",
                             $time, read_data, pc_value);
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (read_data !== want.data)
                    begin
                        $display("%0t: read_data expected %0h got %0h",
                                 $time, want.data, read_data);
                        errors++;
                    end
                    if (pc_value !== want.pc)
                    begin
                        $display("%0t: pc_value expected %0h got %0h",
                                 $time, want.pc, pc_value);
                        errors++;
                    end
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, status);
                        errors++;
                    end
                    if (branch_taken !== want.taken)
                    begin
                        $display("%0t: branch_taken expected %0b got %0b",
                                 $time, want.taken, branch_taken);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        for (int i = 0; i < 65536; i++) cpu_mem[i] = 8'h00;
        for (int i = 0; i < NUM_REGS; i++) cpu_regs[i] = 16'h0000;
        cpu_pc = 8'h00;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Register reads at the edges of the index range, memory at the top address
        push_item(trcs_pkg::CMD_RREG, 16'h0000, 8'h00);
        push_item(trcs_pkg::CMD_RREG, 16'(NUM_REGS - 1), 8'hFF);
        push_item(trcs_pkg::CMD_RREG, 16'(NUM_REGS), 8'h00);
        push_item(trcs_pkg::CMD_RREG, 16'hFFFF, 8'h00);
        push_item(trcs_pkg::CMD_WRITE, 16'hFFFF, 8'hA5);
        push_item(trcs_pkg::CMD_READ, 16'hFFFF, 8'h00);
        push_item(trcs_pkg::CMD_READ, 16'h8000, 8'hFF);
        // blank memory at pc zero decodes as an unknown opcode
        push_item(trcs_pkg::CMD_EXEC, 16'h0000, 8'h00);
        wait_idle(1);
        // taken jump to 0xFD so that the next instruction straddles the pc wrap
        load_and_run({16'hFFFD, 16'h0001, trcs_pkg::OP_JNE}, 5);
        wait_idle(0);
        // load from the top address: high byte comes from address zero
        load_and_run({8'h00, 8'h00, 16'hFFFF, trcs_pkg::OP_LOAD}, 4);
        wait_idle(0);
        load_and_run({16'h0000, 8'h00, 8'h00, trcs_pkg::OP_ADD}, 3);
        wait_idle(0);
        // copy into a register that does not exist
        load_and_run({16'h0000, 8'(NUM_REGS), 8'h00, trcs_pkg::OP_MOVR}, 3);
        wait_idle(0);
        load_and_run({8'h00, 16'hFFFF, 8'h00, trcs_pkg::OP_STORE}, 4);
        push_item(trcs_pkg::CMD_READ, 16'h0000, 8'h00);
        wait_idle(0);
        load_and_run({8'h00, 8'hFF, 16'hFFFF, trcs_pkg::OP_MOVI}, 4);
        push_item(trcs_pkg::CMD_RREG, 16'h0000, 8'h00);

        // Mostly well-formed instructions, with bursts of raw commands mixed in
        while (queued_total < TOTAL_ITEMS)
        begin
            wait_idle($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 9) < 2)
            begin
                repeat ($urandom_range(1, 6))
                    push_item(2'($urandom_range(0, 3)),
                              $urandom_range(0, 1) ? 16'($urandom)
                                                   : 16'($urandom_range(0, 15)),
                              8'($urandom));
            end
            else
            begin
                queue_random_instr();
                if ($urandom_range(0, 3) == 0)
                begin
                    if ($urandom_range(0, 1)) push_item(trcs_pkg::CMD_RREG,
                                                        16'($urandom_range(0, NUM_REGS)),
                                                        8'($urandom));
                    else push_item(trcs_pkg::CMD_READ, pick_data_addr(), 8'($urandom));
                end
            end
        end

        // Drain, then give any stray result word time to show up
        wait_idle(1);
        repeat (20) @(negedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/trcs_pkg.sv
rtl/core/trcs_mem.sv
rtl/core/tiny_register_cpu_step.sv
tb/sv/tiny_register_cpu_step_tb.sv
